/* hdl/cci_pkg.sv */
package cci_pkg;

  localparam int CW        = 32;            // coordinate word
  localparam int RW        = CW - 1;        // radius word
  localparam int DW        = CW + 1;        // center difference
  localparam int TOL_W     = 16;
  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(66);

  localparam int SQ_IN_W   = 2 * DW;        // radicand
  localparam int SQ_OUT_W  = DW;            // root
  localparam int SQ_LAT    = SQ_OUT_W;

  localparam int DV_NUM_W  = 2 * DW + 1;
  localparam int DV_DEN_W  = SQ_OUT_W + 1;
  localparam int DV_Q_W    = CW;
  localparam int DV_LAT    = DV_Q_W;

  localparam logic [1:0] PC_NONE = 2'd0;
  localparam logic [1:0] PC_ONE  = 2'd1;
  localparam logic [1:0] PC_TWO  = 2'd2;

  typedef struct packed {
    logic signed [CW-1:0] center1_x;
    logic signed [CW-1:0] center1_y;
    logic [RW-1:0]        radius1;
    logic signed [CW-1:0] center2_x;
    logic signed [CW-1:0] center2_y;
    logic [RW-1:0]        radius2;
  } in_t;

  typedef struct packed {
    logic [1:0]           point_count;
    logic                 coincident;
    logic signed [CW-1:0] point1_x;
    logic signed [CW-1:0] point1_y;
    logic signed [CW-1:0] point2_x;
    logic signed [CW-1:0] point2_y;
    logic                 status;
  } out_t;

endpackage

/* hdl/cci_isqrt.sv */
// Pipelined integer square root, one root bit per stage.
module cci_isqrt import cci_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [SQ_IN_W-1:0]  rad_i,
  output logic                valid_o,
  output logic [SQ_OUT_W-1:0] root_o
);

  localparam int N  = SQ_OUT_W;
  localparam int TW = SQ_IN_W + 1;

  logic [SQ_IN_W-1:0]  rem_q [N];
  logic [SQ_IN_W-1:0]  rem_d [N];
  logic [SQ_IN_W-1:0]  rin   [N];
  logic [SQ_OUT_W-1:0] res_q [N];
  logic [SQ_OUT_W-1:0] res_d [N];
  logic [SQ_OUT_W-1:0] sin   [N];
  logic                vld_q [N];
  logic                vin   [N];

  always_comb begin
    rin[0] = rad_i;
    sin[0] = '0;
    vin[0] = valid_i;
    for (int j = 1; j < N; j++) begin
      rin[j] = rem_q[j-1];
      sin[j] = res_q[j-1];
      vin[j] = vld_q[j-1];
    end
  end

  // remainder keeps n - res^2; candidate bit b adds (res << (b+1)) + 4^b
  always_comb begin
    logic [TW-1:0] trial;
    for (int j = 0; j < N; j++) begin
      trial = (TW'(sin[j]) << (N - j)) | (TW'(1) << (2 * (N - 1 - j)));
      if (TW'(rin[j]) >= trial) begin
        rem_d[j] = SQ_IN_W'(TW'(rin[j]) - trial);
        res_d[j] = sin[j] | (SQ_OUT_W'(1) << (N - 1 - j));
      end else begin
        rem_d[j] = rin[j];
        res_d[j] = sin[j];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < N; j++) vld_q[j] <= 1'b0;
    end else if (en_i) begin
      for (int j = 0; j < N; j++) vld_q[j] <= vin[j];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < N; j++) begin
        rem_q[j] <= rem_d[j];
        res_q[j] <= res_d[j];
      end
    end
  end

  assign valid_o = vld_q[N-1];
  assign root_o  = res_q[N-1];

endmodule

/* hdl/cci_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
// Caller keeps num_i below den_i << DV_Q_W.
module cci_div import cci_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [DV_NUM_W-1:0] num_i,
  input  logic [DV_DEN_W-1:0] den_i,
  output logic                valid_o,
  output logic [DV_Q_W-1:0]   quot_o
);

  localparam int N = DV_Q_W;

  logic [DV_NUM_W-1:0] rem_q [N];
  logic [DV_NUM_W-1:0] rem_d [N];
  logic [DV_NUM_W-1:0] rin   [N];
  logic [DV_DEN_W-1:0] den_q [N];
  logic [DV_DEN_W-1:0] din   [N];
  logic [DV_Q_W-1:0]   quo_q [N];
  logic [DV_Q_W-1:0]   quo_d [N];
  logic [DV_Q_W-1:0]   qin   [N];
  logic                vld_q [N];
  logic                vin   [N];

  always_comb begin
    rin[0] = num_i;
    din[0] = den_i;
    qin[0] = '0;
    vin[0] = valid_i;
    for (int j = 1; j < N; j++) begin
      rin[j] = rem_q[j-1];
      din[j] = den_q[j-1];
      qin[j] = quo_q[j-1];
      vin[j] = vld_q[j-1];
    end
  end

  always_comb begin
    logic [DV_NUM_W-1:0] dsh;
    for (int j = 0; j < N; j++) begin
      dsh = DV_NUM_W'(din[j]) << (N - 1 - j);
      if (rin[j] >= dsh) begin
        rem_d[j] = rin[j] - dsh;
        quo_d[j] = qin[j] | (DV_Q_W'(1) << (N - 1 - j));
      end else begin
        rem_d[j] = rin[j];
        quo_d[j] = qin[j];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < N; j++) vld_q[j] <= 1'b0;
    end else if (en_i) begin
      for (int j = 0; j < N; j++) vld_q[j] <= vin[j];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < N; j++) begin
        rem_q[j] <= rem_d[j];
        den_q[j] <= din[j];
        quo_q[j] <= quo_d[j];
      end
    end
  end

  assign valid_o = vld_q[N-1];
  assign quot_o  = quo_q[N-1];

endmodule

/* hdl/circle_circle_intersection_2d.sv */
// Throughput: one transaction per cycle; the path is two bit-serial square roots (33
//   stages each) and two banks of bit-serial dividers (32 stages each) plus glue stages.
// The whole pipeline holds when a result waits on out_stall_i.
// Reset (rst_ni low, async) clears all valid bits and sets tolerance to 66.
module circle_circle_intersection_2d import cci_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [TOL_W-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_t              in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_t             out_data_o
);

  localparam int RSQW = 2 * RW;        // radius squared
  localparam int NUMW = DV_NUM_W;
  localparam int DSTW = SQ_OUT_W;      // center distance
  localparam int DFW  = DW + 2;        // tangency differences
  localparam int PW   = DW + CW;       // coordinate products
  localparam int SW   = PW + 1;        // product sums
  localparam int OW   = CW + 2;        // point before saturation

  typedef struct packed {
    logic coinc;
    logic apart;
    logic tang;
  } flg_t;

  typedef struct packed {
    logic signed [CW-1:0] c1x;
    logic signed [CW-1:0] c1y;
    logic [RW-1:0]        r1;
    logic [RW-1:0]        r2;
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic [DW-1:0]        adx;
    logic [DW-1:0]        ady;
  } s0_t;

  typedef struct packed {
    logic signed [CW-1:0] c1x;
    logic signed [CW-1:0] c1y;
    logic [RW-1:0]        r1;
    logic [RW-1:0]        r2;
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic [SQ_IN_W-1:0]   ax2;
    logic [SQ_IN_W-1:0]   ay2;
    logic [RSQW-1:0]      r1sq;
    logic [RSQW-1:0]      r2sq;
  } s1_t;

  typedef struct packed {
    logic signed [CW-1:0] c1x;
    logic signed [CW-1:0] c1y;
    logic [RW-1:0]        r1;
    logic [RW-1:0]        r2;
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic [SQ_IN_W-1:0]   d2;
    logic [RSQW-1:0]      rdiff;
    logic [RSQW-1:0]      r1sq;
  } s2_t;

  // rides alongside the distance root
  typedef struct packed {
    logic signed [CW-1:0] c1x;
    logic signed [CW-1:0] c1y;
    logic [RW-1:0]        r1;
    logic [RW-1:0]        r2;
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic [NUMW-1:0]      num;
    logic [RSQW-1:0]      r1sq;
  } sa_t;

  typedef struct packed {
    logic signed [CW-1:0] c1x;
    logic signed [CW-1:0] c1y;
    logic [RW-1:0]        r1;
    logic [RSQW-1:0]      r1sq;
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic [DSTW-1:0]      cdist;
    logic signed [DFW-1:0] diff1;
    logic signed [DFW-1:0] diff2;
    logic [RW-1:0]        rdd;
    logic [NUMW-1:0]      dnum;
    logic [DV_DEN_W-1:0]  den2;
  } s4_t;

  // rides alongside the chord-foot divider
  typedef struct packed {
    logic signed [CW-1:0] c1x;
    logic signed [CW-1:0] c1y;
    logic [RW-1:0]        r1;
    logic [RSQW-1:0]      r1sq;
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic [DSTW-1:0]      cdist;
    flg_t                 flg;
    logic                 sat;
  } sb_t;

  typedef struct packed {
    logic signed [CW-1:0] c1x;
    logic signed [CW-1:0] c1y;
    logic [RSQW-1:0]      r1sq;
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic [DSTW-1:0]      cdist;
    logic [RW-1:0]        d;
    flg_t                 flg;
  } s6_t;

  // rides alongside the offset root
  typedef struct packed {
    logic signed [CW-1:0] c1x;
    logic signed [CW-1:0] c1y;
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic [DSTW-1:0]      cdist;
    logic [RW-1:0]        d;
    flg_t                 flg;
  } sc_t;

  typedef struct packed {
    logic signed [CW-1:0] c1x;
    logic signed [CW-1:0] c1y;
    logic [DSTW-1:0]      cdist;
    flg_t                 flg;
    logic signed [PW-1:0] xd;
    logic signed [PW-1:0] yd;
    logic signed [PW-1:0] xk;
    logic signed [PW-1:0] yk;
  } s9_t;

  typedef struct packed {
    logic signed [CW-1:0] c1x;
    logic signed [CW-1:0] c1y;
    logic [DSTW-1:0]      cdist;
    flg_t                 flg;
    logic signed [SW-1:0] s1x;
    logic signed [SW-1:0] s1y;
    logic signed [SW-1:0] s2x;
    logic signed [SW-1:0] s2y;
  } s10_t;

  // rides alongside the four point dividers
  typedef struct packed {
    logic signed [CW-1:0] c1x;
    logic signed [CW-1:0] c1y;
    logic [3:0]           neg;
    flg_t                 flg;
  } sd_t;

  function automatic logic signed [CW-1:0] sat_coord(logic signed [OW-1:0] v);
    logic signed [OW-1:0] cmax;
    logic signed [OW-1:0] cmin;
    cmax = OW'({1'b0, {(CW-1){1'b1}}});
    cmin = -cmax - OW'(1);
    if (v > cmax)      return cmax[CW-1:0];
    else if (v < cmin) return cmin[CW-1:0];
    else               return v[CW-1:0];
  endfunction

  logic             en;
  logic [TOL_W-1:0] tol_q;

  logic  v0_q, v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q, v9_q, v10_q, v11_q;
  s0_t   s0_d, s0_q;
  s1_t   s1_d, s1_q;
  s2_t   s2_d, s2_q;
  sa_t   s3_d, s3_q;
  logic [SQ_IN_W-1:0] d2_q;
  s4_t   s4_d, s4_q;
  sb_t   s5_d, s5_q;
  logic [NUMW-1:0]     dvn_d, dvn_q;
  s6_t   s6_d, s6_q;
  s6_t   s7_q;
  logic [RSQW-1:0]     dsq_q;
  sc_t   s8_q;
  logic [SQ_IN_W-1:0]  kr_q;
  s9_t   s9_d, s9_q;
  s10_t  s10_d, s10_q;
  sd_t   s11_d, s11_q;
  logic [NUMW-1:0]     mag_d [4];
  logic [NUMW-1:0]     mag_q [4];
  logic [DV_DEN_W-1:0] pden_q;
  out_t  out_d, out_q;
  logic  out_valid_q;

  sa_t   sa_q [SQ_LAT];
  sb_t   sb_q [DV_LAT];
  sc_t   sc_q [SQ_LAT];
  sd_t   sd_q [DV_LAT];

  logic                dist_vld, foot_vld, k_vld;
  logic [SQ_OUT_W-1:0] dist_root, k_root;
  logic [DV_Q_W-1:0]   foot_q;
  logic [3:0]          pt_vld;
  logic [DV_Q_W-1:0]   pt_quot [4];

  // Whole pipeline advances unless a finished result is held back.
  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TOL_RESET;
    end else if (cfg_we_i) begin
      tol_q <= cfg_wdata_i;
    end
  end

  // ---- stage 0: order circles (larger radius first), center offsets
  always_comb begin
    logic swap;
    swap = in_data_i.radius1 < in_data_i.radius2;
    s0_d.c1x = swap ? in_data_i.center2_x : in_data_i.center1_x;
    s0_d.c1y = swap ? in_data_i.center2_y : in_data_i.center1_y;
    s0_d.r1  = swap ? in_data_i.radius2   : in_data_i.radius1;
    s0_d.r2  = swap ? in_data_i.radius1   : in_data_i.radius2;
    s0_d.dx  = swap ? DW'(in_data_i.center1_x) - DW'(in_data_i.center2_x)
                    : DW'(in_data_i.center2_x) - DW'(in_data_i.center1_x);
    s0_d.dy  = swap ? DW'(in_data_i.center1_y) - DW'(in_data_i.center2_y)
                    : DW'(in_data_i.center2_y) - DW'(in_data_i.center1_y);
    s0_d.adx = s0_d.dx[DW-1] ? DW'(-s0_d.dx) : DW'(s0_d.dx);
    s0_d.ady = s0_d.dy[DW-1] ? DW'(-s0_d.dy) : DW'(s0_d.dy);
  end

  // ---- stage 1: squares
  always_comb begin
    s1_d.c1x  = s0_q.c1x;
    s1_d.c1y  = s0_q.c1y;
    s1_d.r1   = s0_q.r1;
    s1_d.r2   = s0_q.r2;
    s1_d.dx   = s0_q.dx;
    s1_d.dy   = s0_q.dy;
    s1_d.ax2  = SQ_IN_W'(s0_q.adx) * SQ_IN_W'(s0_q.adx);
    s1_d.ay2  = SQ_IN_W'(s0_q.ady) * SQ_IN_W'(s0_q.ady);
    s1_d.r1sq = RSQW'(s0_q.r1) * RSQW'(s0_q.r1);
    s1_d.r2sq = RSQW'(s0_q.r2) * RSQW'(s0_q.r2);
  end

  // ---- stage 2: squared distance, radius-square difference
  always_comb begin
    s2_d.c1x   = s1_q.c1x;
    s2_d.c1y   = s1_q.c1y;
    s2_d.r1    = s1_q.r1;
    s2_d.r2    = s1_q.r2;
    s2_d.dx    = s1_q.dx;
    s2_d.dy    = s1_q.dy;
    s2_d.d2    = s1_q.ax2 + s1_q.ay2;
    s2_d.rdiff = s1_q.r1sq - s1_q.r2sq;
    s2_d.r1sq  = s1_q.r1sq;
  end

  // ---- stage 3: chord-foot numerator; d2 goes to the root unit
  always_comb begin
    s3_d.c1x  = s2_q.c1x;
    s3_d.c1y  = s2_q.c1y;
    s3_d.r1   = s2_q.r1;
    s3_d.r2   = s2_q.r2;
    s3_d.dx   = s2_q.dx;
    s3_d.dy   = s2_q.dy;
    s3_d.num  = NUMW'(s2_q.d2) + NUMW'(s2_q.rdiff);
    s3_d.r1sq = s2_q.r1sq;
  end

  cci_isqrt u_dist_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v3_q),
    .rad_i   (d2_q),
    .valid_o (dist_vld),
    .root_o  (dist_root)
  );

  // ---- stage 4: differences for the tangency tests
  always_comb begin
    sa_t a;
    a = sa_q[SQ_LAT-1];
    s4_d.c1x   = a.c1x;
    s4_d.c1y   = a.c1y;
    s4_d.r1    = a.r1;
    s4_d.r1sq  = a.r1sq;
    s4_d.dx    = a.dx;
    s4_d.dy    = a.dy;
    s4_d.cdist = dist_root;
    s4_d.diff1 = $signed(DFW'(dist_root)) - $signed(DFW'(a.r1)) - $signed(DFW'(a.r2));
    s4_d.diff2 = $signed(DFW'(a.r1)) - $signed(DFW'(dist_root)) - $signed(DFW'(a.r2));
    s4_d.rdd   = a.r1 - a.r2;
    s4_d.dnum  = a.num + NUMW'(dist_root);
    s4_d.den2  = {dist_root, 1'b0};
  end

  // ---- stage 5: classify, guard the divider against a foot beyond range
  always_comb begin
    logic signed [DFW-1:0] stol;
    stol = $signed(DFW'(tol_q));
    s5_d.c1x   = s4_q.c1x;
    s5_d.c1y   = s4_q.c1y;
    s5_d.r1    = s4_q.r1;
    s5_d.r1sq  = s4_q.r1sq;
    s5_d.dx    = s4_q.dx;
    s5_d.dy    = s4_q.dy;
    s5_d.cdist = s4_q.cdist;
    s5_d.flg.coinc = (s4_q.cdist <= DSTW'(tol_q)) && (s4_q.rdd <= RW'(tol_q));
    s5_d.flg.apart = (s4_q.diff1 > stol) || (s4_q.diff2 > stol);
    s5_d.flg.tang  = ((s4_q.diff1 <= stol) && (s4_q.diff1 >= -stol)) ||
                     ((s4_q.diff2 <= stol) && (s4_q.diff2 >= -stol));
    // quotient of 2^CW or more always clamps to r1
    s5_d.sat = s4_q.dnum >= (NUMW'(s4_q.den2) << DV_Q_W);
    dvn_d    = s5_d.sat ? '0 : s4_q.dnum;
  end

  // divisor 2 * distance, taken from the same stage as the numerator
  cci_div u_foot_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v5_q),
    .num_i   (dvn_q),
    .den_i   ({s5_q.cdist, 1'b0}),
    .valid_o (foot_vld),
    .quot_o  (foot_q)
  );

  // ---- stage 6: chord foot, clamped to r1; tangent uses r1 directly
  always_comb begin
    sb_t b;
    b = sb_q[DV_LAT-1];
    s6_d.c1x   = b.c1x;
    s6_d.c1y   = b.c1y;
    s6_d.r1sq  = b.r1sq;
    s6_d.dx    = b.dx;
    s6_d.dy    = b.dy;
    s6_d.cdist = b.cdist;
    s6_d.flg   = b.flg;
    if (b.sat || b.flg.tang || (foot_q > DV_Q_W'(b.r1))) s6_d.d = b.r1;
    else                                               s6_d.d = foot_q[RW-1:0];
  end

  cci_isqrt u_k_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v8_q),
    .rad_i   (kr_q),
    .valid_o (k_vld),
    .root_o  (k_root)
  );

  // ---- stage 9: the four products
  always_comb begin
    sc_t c;
    logic signed [PW-1:0] sd;
    logic signed [PW-1:0] sk;
    c  = sc_q[SQ_LAT-1];
    sd = PW'($signed({1'b0, c.d}));
    sk = PW'($signed({1'b0, k_root[RW-1:0]}));
    s9_d.c1x   = c.c1x;
    s9_d.c1y   = c.c1y;
    s9_d.cdist = c.cdist;
    s9_d.flg   = c.flg;
    s9_d.xd    = PW'(c.dx) * sd;
    s9_d.yd    = PW'(c.dy) * sd;
    s9_d.xk    = PW'(c.dx) * sk;
    s9_d.yk    = PW'(c.dy) * sk;
  end

  // ---- stage 10: rotate foot and offset into the frame
  always_comb begin
    s10_d.c1x   = s9_q.c1x;
    s10_d.c1y   = s9_q.c1y;
    s10_d.cdist = s9_q.cdist;
    s10_d.flg   = s9_q.flg;
    s10_d.s1x   = SW'(s9_q.xd) + SW'(s9_q.yk);
    s10_d.s1y   = SW'(s9_q.yd) - SW'(s9_q.xk);
    s10_d.s2x   = SW'(s9_q.xd) - SW'(s9_q.yk);
    s10_d.s2y   = SW'(s9_q.yd) + SW'(s9_q.xk);
  end

  // ---- stage 11: sign and magnitude plus half divisor (round half away)
  always_comb begin
    logic signed [SW-1:0] sv [4];
    sv[0] = s10_q.s1x;
    sv[1] = s10_q.s1y;
    sv[2] = s10_q.s2x;
    sv[3] = s10_q.s2y;
    s11_d.c1x = s10_q.c1x;
    s11_d.c1y = s10_q.c1y;
    s11_d.flg = s10_q.flg;
    for (int j = 0; j < 4; j++) begin
      s11_d.neg[j] = sv[j][SW-1];
      mag_d[j] = (sv[j][SW-1] ? NUMW'(SW'(-sv[j])) : NUMW'(SW'(sv[j])))
               + NUMW'(s10_q.cdist >> 1);
    end
  end

  for (genvar g = 0; g < 4; g++) begin : g_pt_div
    cci_div u_pt_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (v11_q),
      .num_i   (mag_q[g]),
      .den_i   (pden_q),
      .valid_o (pt_vld[g]),
      .quot_o  (pt_quot[g])
    );
  end

  // ---- output stage: restore sign, add first center, saturate, zero unused
  always_comb begin
    sd_t e;
    logic signed [OW-1:0] off [4];
    logic signed [CW-1:0] pt  [4];
    e = sd_q[DV_LAT-1];
    for (int j = 0; j < 4; j++) begin
      off[j] = e.neg[j] ? -$signed(OW'(pt_quot[j])) : $signed(OW'(pt_quot[j]));
    end
    pt[0] = sat_coord(OW'(e.c1x) + off[0]);
    pt[1] = sat_coord(OW'(e.c1y) + off[1]);
    pt[2] = sat_coord(OW'(e.c1x) + off[2]);
    pt[3] = sat_coord(OW'(e.c1y) + off[3]);
    out_d = '0;
    if (e.flg.coinc) begin
      out_d.coincident = 1'b1;
      out_d.status     = 1'b1;
    end else if (e.flg.apart) begin
      out_d.status = 1'b1;
    end else begin
      out_d.point_count = e.flg.tang ? PC_ONE : PC_TWO;
      out_d.point1_x    = pt[0];
      out_d.point1_y    = pt[1];
      out_d.point2_x    = pt[2];
      out_d.point2_y    = pt[3];
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0; v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0;
      v4_q <= 1'b0; v5_q <= 1'b0; v6_q <= 1'b0; v7_q <= 1'b0;
      v8_q <= 1'b0; v9_q <= 1'b0; v10_q <= 1'b0; v11_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v0_q  <= in_valid_i;
      v1_q  <= v0_q;
      v2_q  <= v1_q;
      v3_q  <= v2_q;
      v4_q  <= dist_vld;
      v5_q  <= v4_q;
      v6_q  <= foot_vld;
      v7_q  <= v6_q;
      v8_q  <= v7_q;
      v9_q  <= k_vld;
      v10_q <= v9_q;
      v11_q <= v10_q;
      out_valid_q <= &pt_vld;
    end
  end

  // data path, no reset
  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_q   <= s0_d;
      s1_q   <= s1_d;
      s2_q   <= s2_d;
      s3_q   <= s3_d;
      d2_q   <= s2_q.d2;
      s4_q   <= s4_d;
      s5_q   <= s5_d;
      dvn_q  <= dvn_d;
      s6_q   <= s6_d;
      s7_q   <= s6_q;
      dsq_q  <= RSQW'(s6_q.d) * RSQW'(s6_q.d);
      s8_q.c1x   <= s7_q.c1x;
      s8_q.c1y   <= s7_q.c1y;
      s8_q.dx    <= s7_q.dx;
      s8_q.dy    <= s7_q.dy;
      s8_q.cdist <= s7_q.cdist;
      s8_q.d     <= s7_q.d;
      s8_q.flg   <= s7_q.flg;
      kr_q   <= SQ_IN_W'(s7_q.r1sq - dsq_q);
      s9_q   <= s9_d;
      s10_q  <= s10_d;
      s11_q  <= s11_d;
      pden_q <= DV_DEN_W'(s10_q.cdist);
      for (int j = 0; j < 4; j++) mag_q[j] <= mag_d[j];
      out_q  <= out_d;

      sa_q[0] <= s3_q;
      sc_q[0] <= s8_q;
      for (int j = 1; j < SQ_LAT; j++) begin
        sa_q[j] <= sa_q[j-1];
        sc_q[j] <= sc_q[j-1];
      end
      sb_q[0] <= s5_q;
      sd_q[0] <= s11_q;
      for (int j = 1; j < DV_LAT; j++) begin
        sb_q[j] <= sb_q[j-1];
        sd_q[j] <= sd_q[j-1];
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // no-intersection results carry no points
  a_unused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.status |->
      out_q.point_count == PC_NONE && out_q.point1_x == '0 && out_q.point1_y == '0 &&
      out_q.point2_x == '0 && out_q.point2_y == '0)
    else $error("points not cleared on no-intersection result");

  // tangent point is repeated
  a_tangent_repeat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.point_count == PC_ONE |->
      out_q.point2_x == out_q.point1_x && out_q.point2_y == out_q.point1_y)
    else $error("tangent result with two distinct points");

  // coincidence implies failure status
  a_coinc_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.coincident |-> out_q.status && out_q.point_count == PC_NONE)
    else $error("coincident result without failure status");

  // the four point dividers stay in lockstep
  a_div_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pt_vld == 4'b0000 || pt_vld == 4'b1111)
    else $error("point dividers out of step");

endmodule
